// ----- rtl/core/cpt_pkg.sv -----
package cpt_pkg;

    localparam int KIND_BITS = 3;

    typedef logic [KIND_BITS-1:0] kind_t;

    localparam kind_t KIND_CIRCLE_CIRCLE = 3'd0;
    localparam kind_t KIND_BOX_BOX       = 3'd1;
    localparam kind_t KIND_CIRCLE_BOX    = 3'd2;
    localparam kind_t KIND_POINT_CIRCLE  = 3'd3;
    localparam kind_t KIND_POINT_BOX     = 3'd4;

endpackage

// ----- rtl/core/collision_pair_test.sv -----
// Pair overlap tester for circles, axis-aligned boxes and points.
// Input channel: pair_valid/pair_ready carries one word with the kind and
// two operands, signed Q16.16 centers and unsigned half extents or radii.
// Output channel: hit_valid/hit_ready returns one word per input word, in
// order, with hit set when the operands overlap or the point lies inside.
// One word is accepted in every cycle while the receiver keeps up, since
// the work runs through six register stages: differences, magnitudes,
// per-kind operand selection, partial squares, square assembly, and the
// final add and compare that feeds the output register.
// Every stage holds its word while the stage after it is full and stalled,
// so a stalled receiver fills the pipeline and then pair_ready drops; empty
// stages keep taking words in the meantime. Nothing is lost or repeated.
// Reset clears every stage valid bit; the pipeline then starts empty with
// pair_ready high.
module collision_pair_test #(
    parameter int COORD_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pair_valid,
    output logic                         pair_ready,
    input  cpt_pkg::kind_t               kind,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic        [COORD_BITS-2:0] a_extent_x,
    input  logic        [COORD_BITS-2:0] a_extent_y,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic        [COORD_BITS-2:0] b_extent_x,
    input  logic        [COORD_BITS-2:0] b_extent_y,
    output logic                         hit_valid,
    input  logic                         hit_ready,
    output logic                         hit
);

    localparam int W    = COORD_BITS + 1;
    localparam int LO_W = (W + 1) / 2;
    localparam int HI_W = W - LO_W;
    localparam int SQ_W = 2 * W;
    localparam int NOPS = 3;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic adv1, adv2, adv3, adv4, adv5, adv6;

    assign adv6 = !v6_reg || hit_ready;
    assign adv5 = !v5_reg || adv6;
    assign adv4 = !v4_reg || adv5;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign pair_ready = adv1;
    assign hit_valid  = v6_reg;

    // Stage 1: coordinate differences and extent sums.
    cpt_pkg::kind_t         k1_reg;
    logic signed [W-1:0]    dx1_reg, dy1_reg;
    logic [COORD_BITS-1:0]  sx1_reg, sy1_reg;
    logic [COORD_BITS-2:0]  aex1_reg, bex1_reg, bey1_reg;

    // Stage 2: magnitudes of the differences.
    cpt_pkg::kind_t         k2_reg;
    logic [W-1:0]           mx2_reg, my2_reg;
    logic [COORD_BITS-1:0]  sx2_reg, sy2_reg;
    logic [COORD_BITS-2:0]  aex2_reg, bex2_reg, bey2_reg;

    // Stage 3: operands of the squared test, or the finished box result.
    logic [W-1:0]           op3_reg [NOPS];
    logic [W-1:0]           op3_next [NOPS];
    logic                   sq3_reg, sq3_next;
    logic                   box3_reg, box3_next;

    // Stage 4: partial products of the three squares.
    logic [2*HI_W-1:0]      hh4_reg [NOPS];
    logic [HI_W+LO_W-1:0]   hl4_reg [NOPS];
    logic [2*LO_W-1:0]      ll4_reg [NOPS];
    logic                   sq4_reg, box4_reg;

    // Stage 5: assembled squares.
    logic [SQ_W-1:0]        sq5_reg [NOPS];
    logic [SQ_W-1:0]        sq5_next [NOPS];
    logic                   sel5_reg, box5_reg;

    // Stage 6: output register.
    logic                   hit_reg, hit_next;

    logic [W-1:0]           mx2_next, my2_next;
    logic [SQ_W:0]          dist_sq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= pair_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
            if (adv5)
            begin
                v5_reg <= v4_reg;
            end
            if (adv6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            k1_reg   <= kind;
            dx1_reg  <= W'($signed({a_x[COORD_BITS-1], a_x}) -
                           $signed({b_x[COORD_BITS-1], b_x}));
            dy1_reg  <= W'($signed({a_y[COORD_BITS-1], a_y}) -
                           $signed({b_y[COORD_BITS-1], b_y}));
            sx1_reg  <= {1'b0, a_extent_x} + {1'b0, b_extent_x};
            sy1_reg  <= {1'b0, a_extent_y} + {1'b0, b_extent_y};
            aex1_reg <= a_extent_x;
            bex1_reg <= b_extent_x;
            bey1_reg <= b_extent_y;
        end
    end

    always_comb
    begin
        mx2_next = dx1_reg[W-1] ? W'(-dx1_reg) : W'(dx1_reg);
        my2_next = dy1_reg[W-1] ? W'(-dy1_reg) : W'(dy1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            k2_reg   <= k1_reg;
            mx2_reg  <= mx2_next;
            my2_reg  <= my2_next;
            sx2_reg  <= sx1_reg;
            sy2_reg  <= sy1_reg;
            aex2_reg <= aex1_reg;
            bex2_reg <= bex1_reg;
            bey2_reg <= bey1_reg;
        end
    end

    always_comb
    begin
        op3_next[0] = mx2_reg;
        op3_next[1] = my2_reg;
        op3_next[2] = '0;
        sq3_next    = 1'b0;
        box3_next   = 1'b0;
        unique case (k2_reg)
            cpt_pkg::KIND_CIRCLE_CIRCLE:
            begin
                op3_next[2] = W'(sx2_reg);
                sq3_next    = 1'b1;
            end
            cpt_pkg::KIND_BOX_BOX:
            begin
                box3_next = (mx2_reg <= W'(sx2_reg)) && (my2_reg <= W'(sy2_reg));
            end
            cpt_pkg::KIND_CIRCLE_BOX:
            begin
                // Distance from the offset to the box interval on each axis.
                op3_next[0] = (mx2_reg > W'(bex2_reg)) ? mx2_reg - W'(bex2_reg) : '0;
                op3_next[1] = (my2_reg > W'(bey2_reg)) ? my2_reg - W'(bey2_reg) : '0;
                op3_next[2] = W'(aex2_reg);
                sq3_next    = 1'b1;
            end
            cpt_pkg::KIND_POINT_CIRCLE:
            begin
                op3_next[2] = W'(bex2_reg);
                sq3_next    = 1'b1;
            end
            cpt_pkg::KIND_POINT_BOX:
            begin
                box3_next = (mx2_reg <= W'(bex2_reg)) && (my2_reg <= W'(bey2_reg));
            end
            default:
            begin
                box3_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            for (int i = 0; i < NOPS; i++)
            begin
                op3_reg[i] <= op3_next[i];
            end
            sq3_reg  <= sq3_next;
            box3_reg <= box3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            for (int i = 0; i < NOPS; i++)
            begin
                hh4_reg[i] <= op3_reg[i][W-1:LO_W] * op3_reg[i][W-1:LO_W];
                hl4_reg[i] <= op3_reg[i][W-1:LO_W] * op3_reg[i][LO_W-1:0];
                ll4_reg[i] <= op3_reg[i][LO_W-1:0] * op3_reg[i][LO_W-1:0];
            end
            sq4_reg  <= sq3_reg;
            box4_reg <= box3_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NOPS; i++)
        begin
            sq5_next[i] = (SQ_W'(hh4_reg[i]) << (2 * LO_W)) +
                          (SQ_W'(hl4_reg[i]) << (LO_W + 1)) +
                          SQ_W'(ll4_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv5)
        begin
            for (int i = 0; i < NOPS; i++)
            begin
                sq5_reg[i] <= sq5_next[i];
            end
            sel5_reg <= sq4_reg;
            box5_reg <= box4_reg;
        end
    end

    always_comb
    begin
        dist_sq  = {1'b0, sq5_reg[0]} + {1'b0, sq5_reg[1]};
        hit_next = sel5_reg ? (dist_sq < {1'b0, sq5_reg[2]}) : box5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv6)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

`ifndef SYNTHESIS
    a_empty_first_stage_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg |-> pair_ready)
        else $error("first stage empty but input not ready");

    a_magnitude_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (mx2_reg <= (W'(1) << COORD_BITS)) && (my2_reg <= (W'(1) << COORD_BITS)))
        else $error("difference magnitude out of range");

    a_no_kind_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && (k2_reg > cpt_pkg::KIND_POINT_BOX))
            |-> (!sq3_next && !box3_next))
        else $error("unknown kind produced a test");

    a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && !adv6) |=> (v5_reg && $stable(sel5_reg) && $stable(box5_reg)))
        else $error("stalled stage lost its word");

    a_box_excludes_square: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> !(sq3_reg && box3_reg))
        else $error("both result paths selected");
`endif

endmodule
